/* sv/dshc_pkg.sv */
// Shared types and constants for the DER SEQUENCE header checker.
package dshc_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned CNT_W         = 33;
    localparam int unsigned LEN_W         = 32;
    localparam int unsigned OCT_W         = 3;
    localparam int unsigned MAX_LEN_OCTS  = 4;

    localparam logic [BYTE_W-1:0] SEQ_TAG  = 8'h30;
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  HDR_BYTES = 33'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_TAG   = 3'd2,
        ST_INDEF     = 3'd3,
        ST_TOO_MANY  = 3'd4,
        ST_TRUNC     = 3'd5,
        ST_MISMATCH  = 3'd6
    } status_t;

    // one registered input item
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
    } byte_item_t;

    // one check result
    typedef struct packed {
        status_t           status;
        logic [LEN_W-1:0]  content_length;
        logic [CNT_W-1:0]  expected_total;
        logic [CNT_W-1:0]  bytes_seen;
    } result_t;

endpackage

/* sv/dshc_in_stage.sv */
// Input register stage for payload bytes.
module dshc_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dshc_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          last_byte,
    input  logic                          fire,
    output dshc_pkg::byte_item_t          item
);
    import dshc_pkg::*;

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              last_reg;
    logic              accept;

    // stage frees up when its item is consumed in the same cycle
    assign in_stall = valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;
    assign item.last  = last_reg;

endmodule

/* sv/dshc_hdr_track.sv */
// Header tracking state and the final check evaluation.
module dshc_hdr_track (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dshc_pkg::byte_item_t  item,
    input  logic                  fire,
    output dshc_pkg::result_t     result
);
    import dshc_pkg::*;

    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_upd;
    logic              tag_bad_reg, tag_bad_next, tag_bad_upd;
    logic [BYTE_W-1:0] len_ind_reg, len_ind_next, len_ind_upd;
    logic [LEN_W-1:0]  acc_reg, acc_next, acc_upd;
    logic [OCT_W-1:0]  oct_reg, oct_next, oct_upd;
    logic [6:0]        ind_n;
    logic [6:0]        n_upd;
    logic [CNT_W-1:0]  total_long;
    logic [CNT_W-1:0]  total_short;

    assign ind_n = item.data[6:0];

    // state after taking this byte
    always_comb
    begin
        tag_bad_upd = tag_bad_reg;
        len_ind_upd = len_ind_reg;
        acc_upd     = acc_reg;
        oct_upd     = oct_reg;
        if (cnt_reg == '0)
        begin
            tag_bad_upd = (item.data != SEQ_TAG);
        end
        else if (cnt_reg == CNT_W'(1))
        begin
            len_ind_upd = item.data;
            if (item.data[7] && (ind_n != 7'd0) && (ind_n <= 7'(MAX_LEN_OCTS)))
            begin
                oct_upd = ind_n[OCT_W-1:0];
            end
        end
        else if (oct_reg != '0)
        begin
            acc_upd = {acc_reg[LEN_W-BYTE_W-1:0], item.data};
            oct_upd = oct_reg - OCT_W'(1);
        end
        cnt_upd = (cnt_reg != CNT_MAX) ? cnt_reg + CNT_W'(1) : cnt_reg;
    end

    // frame ends on the last byte: everything back to reset
    always_comb
    begin
        cnt_next     = cnt_reg;
        tag_bad_next = tag_bad_reg;
        len_ind_next = len_ind_reg;
        acc_next     = acc_reg;
        oct_next     = oct_reg;
        if (fire)
        begin
            if (item.last)
            begin
                cnt_next     = '0;
                tag_bad_next = 1'b0;
                len_ind_next = '0;
                acc_next     = '0;
                oct_next     = '0;
            end
            else
            begin
                cnt_next     = cnt_upd;
                tag_bad_next = tag_bad_upd;
                len_ind_next = len_ind_upd;
                acc_next     = acc_upd;
                oct_next     = oct_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            tag_bad_reg <= 1'b0;
            len_ind_reg <= '0;
            acc_reg     <= '0;
            oct_reg     <= '0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            tag_bad_reg <= tag_bad_next;
            len_ind_reg <= len_ind_next;
            acc_reg     <= acc_next;
            oct_reg     <= oct_next;
        end
    end

    // check evaluation, first failing check wins
    assign n_upd       = len_ind_upd[6:0];
    assign total_short = HDR_BYTES + CNT_W'(len_ind_upd[6:0]);
    assign total_long  = HDR_BYTES + CNT_W'(n_upd) + CNT_W'(acc_upd);

    always_comb
    begin
        result.status         = ST_OK;
        result.content_length = '0;
        result.expected_total = '0;
        result.bytes_seen     = cnt_upd;
        if (cnt_upd < HDR_BYTES)
        begin
            result.status = ST_SHORT;
        end
        else if (tag_bad_upd)
        begin
            result.status = ST_BAD_TAG;
        end
        else if (!len_ind_upd[7])
        begin
            result.content_length = LEN_W'(len_ind_upd[6:0]);
            result.expected_total = total_short;
            result.status = (cnt_upd == total_short) ? ST_OK : ST_MISMATCH;
        end
        else if (n_upd == 7'd0)
        begin
            result.status = ST_INDEF;
        end
        else if (n_upd > 7'(MAX_LEN_OCTS))
        begin
            result.status = ST_TOO_MANY;
        end
        else if (cnt_upd < HDR_BYTES + CNT_W'(n_upd))
        begin
            result.status = ST_TRUNC;
        end
        else
        begin
            result.content_length = acc_upd;
            result.expected_total = total_long;
            result.status = (cnt_upd == total_long) ? ST_OK : ST_MISMATCH;
        end
    end

`ifndef SYNTH
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.last |=> (cnt_reg == '0) && (oct_reg == '0) && (acc_reg == '0))
        else $error("frame state not cleared after last byte");

    a_oct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oct_reg <= OCT_W'(MAX_LEN_OCTS))
        else $error("pending length octets out of range");
`endif

endmodule

/* sv/dshc_out_stage.sv */
// Result register for check results.
module dshc_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  dshc_pkg::result_t             result,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [dshc_pkg::LEN_W-1:0]    content_length,
    output logic [dshc_pkg::CNT_W-1:0]    expected_total,
    output logic [dshc_pkg::CNT_W-1:0]    bytes_seen
);
    import dshc_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    always_comb
    begin
        valid_next = valid_reg && out_stall;
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign out_valid      = valid_reg;
    assign status         = res_reg.status;
    assign content_length = res_reg.content_length;
    assign expected_total = res_reg.expected_total;
    assign bytes_seen     = res_reg.bytes_seen;

`ifndef SYNTH
    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(valid_reg && out_stall))
        else $error("result overwritten while stalled");

    a_ok_sizes: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (res_reg.status == ST_OK) |-> res_reg.bytes_seen == res_reg.expected_total)
        else $error("ok status with size disagreement");

    a_undecoded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (res_reg.status != ST_OK) && (res_reg.status != ST_MISMATCH)
        |-> (res_reg.content_length == '0) && (res_reg.expected_total == '0))
        else $error("length fields set for an undecoded header");
`endif

endmodule

/* sv/der_sequence_header_check_core.sv */
// Top level of the DER SEQUENCE header checker.
// Takes a payload one byte per item (last_byte marks the end) and, for each
// payload, gives one result item: the status of the first failing check
// (too short, bad tag, indefinite length, too many length octets,
// truncated length field, size mismatch) or ok, with the decoded content
// length, the expected total size and the number of bytes seen. Bytes are
// accepted one per cycle, back to back and across payload boundaries,
// unless a last byte is held back (see below); a byte is registered in
// the input register, is folded into the header state, and on the last
// byte its result is loaded into the result register, where it waits
// until it is taken. Only a last byte can be held back: it waits while
// the result register still holds an earlier result that is stalled.
// Non-final bytes flow on regardless. The byte count saturates at 2^33-1.
module der_sequence_header_check_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dshc_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [dshc_pkg::LEN_W-1:0]    content_length,
    output logic [dshc_pkg::CNT_W-1:0]    expected_total,
    output logic [dshc_pkg::CNT_W-1:0]    bytes_seen
);
    import dshc_pkg::*;

    byte_item_t item;
    result_t    result;
    logic       fire;
    logic       load;

    // a last byte needs a free result slot, other bytes always proceed
    assign fire = item.valid && (!item.last || !out_valid || !out_stall);
    assign load = fire && item.last;

    dshc_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .fire      (fire),
        .item      (item)
    );

    dshc_hdr_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .fire   (fire),
        .result (result)
    );

    dshc_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .result         (result),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .content_length (content_length),
        .expected_total (expected_total),
        .bytes_seen     (bytes_seen)
    );

`ifndef SYNTH
    // every new result comes from a last byte loaded in the previous cycle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(load))
        else $error("result without a last byte");
`endif

endmodule
